[rtl/core/frot_pkg.sv]
// Shared types, codes and helpers for the I420 frame rotator.
package frot_pkg;

  localparam int unsigned DIM_W = 7;
  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
  localparam int unsigned ADDR_CALC_W = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_ROTATION_MODE = 2'd2;

  localparam logic [1:0] ROT_90   = 2'd0;
  localparam logic [1:0] ROT_180  = 2'd1;
  localparam logic [1:0] ROT_270  = 2'd2;
  localparam logic [1:0] ROT_NONE = 2'd3;

  localparam logic [1:0] PLANE_Y = 2'd0;
  localparam logic [1:0] PLANE_U = 2'd1;
  localparam logic [1:0] PLANE_V = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
  } req_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_frame;
    logic       not_ready;
  } rsp_beat_t;

  typedef struct packed {
    logic [1:0]       reg_index;
    logic [DIM_W-1:0] wdata;
  } cfg_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_DONE
  } frot_state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic mul;
    logic addr;
    logic read;
    logic emit;
  } frot_cmd_t;

  typedef struct packed {
    logic frame_loaded;
    logic out_busy;
  } frot_stat_t;

  // Clamp to 2..max, then force even.
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] m;
    m = (maxv > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(maxv);
    r = (v < DIM_W'(2)) ? DIM_W'(2) : v;
    if (r > m) r = m;
    r[0] = 1'b0;
    if (r < DIM_W'(2)) r = DIM_W'(2);
    return r;
  endfunction

endpackage

[rtl/core/frot_chan_if.sv]
// Valid/ready channel carrying one payload beat.
interface frot_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/i420_frame_rotator.sv]
// Top level of the I420 frame rotator: channels, controller and datapath.
//
//   channel | dir | payload                                  | beat accepted
//   --------+-----+------------------------------------------+------------------
//   cfg     | in  | reg_index (2b), wdata (7b)               | valid & ready
//   req     | in  | command (1b), in_byte (8b)               | valid & ready
//   rsp     | out | out_byte (8b), last_of_frame, not_ready  | valid & ready
//
// Load beats are taken back to back while idle: one store write per cycle.
// A fetch beat passes through idle, multiply, address add, store read and
// result load in order; no new beat is taken until it is back in idle.
// A fetch on an incomplete frame skips to the result and returns not_ready.
// The result register lets the next beat enter while a result waits; a
// fetch that finishes with the result still held stalls until rsp drains.
// rst is synchronous; the frame store is not cleared, so no sweep is needed.
// cfg and req are held not ready during rst; a cfg write takes effect on the
// next cycle.
module i420_frame_rotator import frot_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input logic clk,
  input logic rst,
  frot_chan_if.sink   cfg,
  frot_chan_if.sink   req,
  frot_chan_if.source rsp
);

  frot_cmd_t  cmd;
  frot_stat_t stat;
  logic       req_ready;

  // Ready outside reset; user must send writes only while idle, unenforced.
  assign cfg.ready = !rst;
  assign req.ready = req_ready;

  frot_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.payload.command),
    .stat        (stat),
    .cmd         (cmd),
    .req_ready   (req_ready)
  );

  frot_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_beat  (cfg.payload),
    .req_beat  (req.payload),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_beat  (rsp.payload)
  );

endmodule

[rtl/core/frot_ctrl.sv]
// Sequencer for load and fetch beats of the frame rotator.
module frot_ctrl import frot_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_command,
  input  frot_stat_t stat,
  output frot_cmd_t  cmd,
  output logic       req_ready
);

  frot_state_t state;
  frot_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && req_command == CMD_FETCH) begin
          state_next = stat.frame_loaded ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_next = ST_ADDR;
      ST_ADDR: state_next = ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (!stat.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = (state == ST_IDLE) && !rst;
    cmd       = '0;
    cmd.load  = req_ready && req_valid && (req_command == CMD_LOAD);
    cmd.fetch = req_ready && req_valid && (req_command == CMD_FETCH);
    cmd.mul   = (state == ST_MUL);
    cmd.addr  = (state == ST_ADDR);
    cmd.read  = (state == ST_READ);
    cmd.emit  = (state == ST_DONE) && !stat.out_busy;
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.fetch, cmd.mul, cmd.addr, cmd.read, cmd.emit}))
    else $error("controller issued overlapping commands");

  a_early_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch && !stat.frame_loaded |=> state == ST_DONE)
    else $error("fetch on incomplete frame did not go straight to result");

endmodule

[rtl/core/frot_dpath.sv]
// Frame store, load/readout counters, address math and result register.
module frot_dpath import frot_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  input  cfg_beat_t cfg_beat,
  input  req_beat_t req_beat,
  input  frot_cmd_t cmd,
  output frot_stat_t stat,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_beat_t rsp_beat
);

  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = (AW + 1 > ADDR_CALC_W) ? AW + 1 : ADDR_CALC_W;
  localparam int unsigned LW = 2 * DIM_W;

  logic [7:0] mem [STORE_DEPTH];

  logic [DIM_W-1:0] w_eff, h_eff;
  logic [1:0]       mode;
  logic [AW-1:0]    load_pos;
  logic             frame_loaded;
  logic [1:0]       plane;
  logic [DIM_W-1:0] row, col;

  logic [LW-1:0]    prod_q;
  logic [DIM_W-1:0] x_q;
  logic [LW-1:0]    luma_q;
  logic [1:0]       plane_q;
  logic             last_q;
  logic             nr_q;
  logic [AW-1:0]    addr_q;
  logic [7:0]       rd_q;

  logic [LW-1:0]    luma;
  logic [CW-1:0]    total;
  logic [AW-1:0]    wr_pos;
  logic [CW-1:0]    pos_inc;
  logic [DIM_W-1:0] pw, ph, ocols, orows, x, y;
  logic [DIM_W:0]   col_inc, row_inc;
  logic [CW-1:0]    base;
  logic [CW-1:0]    addr_sum;
  logic             restart;

  assign luma    = w_eff * h_eff;
  assign total   = CW'(luma) + CW'(luma >> 1);
  assign wr_pos  = frame_loaded ? '0 : load_pos;
  assign pos_inc = CW'(wr_pos) + CW'(1);

  // Plane geometry and source coordinate of the next output byte
  always_comb begin
    pw = (plane == PLANE_Y) ? w_eff : (w_eff >> 1);
    ph = (plane == PLANE_Y) ? h_eff : (h_eff >> 1);
    if (mode == ROT_90 || mode == ROT_270) begin
      ocols = ph;
      orows = pw;
    end else begin
      ocols = pw;
      orows = ph;
    end
    unique case (mode)
      ROT_90: begin
        x = row;
        y = ph - DIM_W'(1) - col;
      end
      ROT_180: begin
        x = pw - DIM_W'(1) - col;
        y = ph - DIM_W'(1) - row;
      end
      ROT_270: begin
        x = pw - DIM_W'(1) - row;
        y = col;
      end
      default: begin
        x = col;
        y = row;
      end
    endcase
  end

  assign col_inc = {1'b0, col} + (DIM_W + 1)'(1);
  assign row_inc = {1'b0, row} + (DIM_W + 1)'(1);

  always_comb begin
    unique case (plane_q)
      PLANE_Y: base = '0;
      PLANE_U: base = CW'(luma_q);
      default: base = CW'(luma_q) + CW'(luma_q >> 2);
    endcase
  end

  assign addr_sum = base + CW'(prod_q) + CW'(x_q);
  assign restart  = cmd.load && frame_loaded;

  // Configuration, load position and readout counters
  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff        <= eff_dim(DIM_W'(64), MAX_WIDTH);
      h_eff        <= eff_dim(DIM_W'(64), MAX_HEIGHT);
      mode         <= ROT_90;
      load_pos     <= '0;
      frame_loaded <= 1'b0;
      plane        <= PLANE_Y;
      row          <= '0;
      col          <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_beat.reg_index)
        REG_FRAME_WIDTH, REG_FRAME_HEIGHT: begin
          if (cfg_beat.reg_index == REG_FRAME_WIDTH) begin
            w_eff <= eff_dim(cfg_beat.wdata, MAX_WIDTH);
          end else begin
            h_eff <= eff_dim(cfg_beat.wdata, MAX_HEIGHT);
          end
          load_pos     <= '0;
          frame_loaded <= 1'b0;
          plane        <= PLANE_Y;
          row          <= '0;
          col          <= '0;
        end
        REG_ROTATION_MODE: begin
          mode  <= cfg_beat.wdata[1:0];
          plane <= PLANE_Y;
          row   <= '0;
          col   <= '0;
        end
        default: ;
      endcase
    end else if (cmd.load) begin
      if (restart) begin
        plane <= PLANE_Y;
        row   <= '0;
        col   <= '0;
      end
      if (pos_inc >= total) begin
        frame_loaded <= 1'b1;
        load_pos     <= '0;
      end else begin
        frame_loaded <= 1'b0;
        load_pos     <= pos_inc[AW-1:0];
      end
    end else if (cmd.mul) begin
      if (col_inc >= {1'b0, ocols}) begin
        col <= '0;
        if (row_inc >= {1'b0, orows}) begin
          row   <= '0;
          plane <= (plane == PLANE_V) ? PLANE_Y : plane + 2'd1;
        end else begin
          row <= row_inc[DIM_W-1:0];
        end
      end else begin
        col <= col_inc[DIM_W-1:0];
      end
    end
  end

  // Address pipeline: product, then sum, then store read
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      nr_q <= !frame_loaded;
    end
    if (cmd.mul) begin
      prod_q  <= y * pw;
      x_q     <= x;
      luma_q  <= luma;
      plane_q <= plane;
      last_q  <= (plane == PLANE_V) && (col_inc >= {1'b0, ocols}) &&
                 (row_inc >= {1'b0, orows});
    end
    if (cmd.addr) begin
      addr_q <= addr_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wr_pos] <= req_beat.in_byte;
    end
    if (cmd.read) begin
      rd_q <= mem[addr_q];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_beat.out_byte      <= nr_q ? 8'd0 : rd_q;
      rsp_beat.last_of_frame <= nr_q ? 1'b0 : last_q;
      rsp_beat.not_ready     <= nr_q;
    end
  end

  assign stat.frame_loaded = frame_loaded;
  assign stat.out_busy     = rsp_valid && !rsp_ready;

  a_pos_parked: assert property (@(posedge clk) disable iff (rst)
    frame_loaded |-> load_pos == '0)
    else $error("load position not parked on a complete frame");

  a_plane_range: assert property (@(posedge clk) disable iff (rst)
    plane != 2'd3)
    else $error("readout plane out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !rsp_valid || rsp_ready)
    else $error("result register overwritten before it was taken");

endmodule
